>>> hdl/pcdt_pkg.sv
// ----------------------------------------------------------------------------
// pcdt_pkg
// Shared sizes, mode codes and item types of the palette color dedup table.
// ----------------------------------------------------------------------------
package pcdt_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int TBL_ENTRIES = 255;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam int CODE_W      = 8;
  localparam int COLOR_W     = 32;

  localparam logic [1:0] MODE_CLASSIFY = 2'd0;
  localparam logic [1:0] MODE_LOAD     = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         palette_index;
    logic [COLOR_W-1:0] color_word;
  } pcdt_in_t;

  typedef struct packed {
    logic [CODE_W-1:0]  voxel_code;
    logic               is_new;
    logic [COLOR_W-1:0] new_color;
    logic               table_full;
  } pcdt_out_t;

  // Item as it walks down the row of cells.
  typedef struct packed {
    logic               vld;     // slot holds an item
    logic               clr;     // clear request, empties each cell it passes
    logic               srch;    // color still looking for a match or a free cell
    logic               is_new;  // color was appended by some cell
    logic [CODE_W-1:0]  code;
    logic [COLOR_W-1:0] color;
  } pcdt_qry_t;

endpackage

>>> hdl/pcdt_front.sv
// ----------------------------------------------------------------------------
// pcdt_front
// Palette memory and the entry stage that turns an item into a search item.
// ----------------------------------------------------------------------------
module pcdt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_acc,
  input  pcdt_pkg::pcdt_in_t  in_item,
  output pcdt_pkg::pcdt_qry_t q_out
);
  import pcdt_pkg::*;

  logic [COLOR_W-1:0]   pal_mem [PAL_ENTRIES];
  logic [COLOR_W-1:0]   rd_r;
  logic                 vld_r;
  logic [1:0]           mode_r;
  logic                 rng_r;
  logic [PAL_IDX_W-1:0] addr;
  logic                 rng;

  assign addr = in_item.palette_index[PAL_IDX_W-1:0];
  assign rng  = ({1'b0, in_item.palette_index} < 9'(PAL_ENTRIES));

  always_ff @(posedge clk) begin
    if (in_acc && (in_item.mode == MODE_LOAD) && rng) begin
      pal_mem[addr] <= in_item.color_word;
    end
    if (adv) begin
      rd_r <= pal_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r <= in_item.mode;
      rng_r  <= rng;
    end
  end

  always_comb begin
    q_out        = '0;
    q_out.vld    = vld_r;
    q_out.clr    = (mode_r == MODE_CLEAR);
    q_out.srch   = (mode_r == MODE_CLASSIFY) && rng_r && (rd_r[31:24] != 8'd0);
    q_out.is_new = 1'b0;
    q_out.code   = '0;
    q_out.color  = rd_r;
  end

endmodule

>>> hdl/pcdt_cell.sv
// ----------------------------------------------------------------------------
// pcdt_cell
// One distinct-table entry plus one slot of the item chain.
// ----------------------------------------------------------------------------
module pcdt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [pcdt_pkg::CODE_W-1:0] cell_pos,
  input  pcdt_pkg::pcdt_qry_t      q_in,
  output pcdt_pkg::pcdt_qry_t      q_out
);
  import pcdt_pkg::*;

  logic               ent_vld_r;
  logic               ent_vld_nxt;
  logic [COLOR_W-1:0] ent_color_r;
  logic               q_vld_r;
  pcdt_qry_t          q_r;
  pcdt_qry_t          q_nxt;
  logic               hit;
  logic               take;

  assign hit  = q_in.vld && q_in.srch && ent_vld_r && (ent_color_r == q_in.color);
  assign take = q_in.vld && q_in.srch && !ent_vld_r;

  always_comb begin
    q_nxt       = q_in;
    ent_vld_nxt = ent_vld_r;
    if (q_in.vld && q_in.clr) begin
      ent_vld_nxt = 1'b0;
    end
    if (hit) begin
      q_nxt.srch = 1'b0;
      q_nxt.code = cell_pos;
    end
    if (take) begin
      q_nxt.srch   = 1'b0;
      q_nxt.code   = cell_pos;
      q_nxt.is_new = 1'b1;
      ent_vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      q_vld_r   <= 1'b0;
    end else if (adv) begin
      ent_vld_r <= ent_vld_nxt;
      q_vld_r   <= q_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r <= q_nxt;
      if (take) begin
        ent_color_r <= q_in.color;
      end
    end
  end

  always_comb begin
    q_out     = q_r;
    q_out.vld = q_vld_r;
  end

endmodule

>>> hdl/palette_color_dedup_table.sv
// ----------------------------------------------------------------------------
// palette_color_dedup_table
// Palette lookup with an in-order table of distinct RGBA colors.
// ----------------------------------------------------------------------------
// Every item gives exactly one result item. A load item writes one palette
// slot, a clear item empties the distinct table, and a classify item reads
// the palette color of a voxel index and returns 0 for zero alpha, the
// 1-based table position of a known color, or appends a new color and
// returns its position with is_new set. When all TBL_ENTRIES positions are
// taken, a new color returns code 0 with table_full set. The block takes one
// item per cycle while the row is not stalled, and each item passes first
// through the palette memory read and then through each cell of the row
// that holds the distinct table. Items walk the row in order, so each
// cell has already been updated by every earlier item when a later one
// reaches it. While the result at the end of the row is stalled, the whole
// row holds still.
// ----------------------------------------------------------------------------
module palette_color_dedup_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcdt_pkg::pcdt_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pcdt_pkg::pcdt_out_t out_item
);
  import pcdt_pkg::*;

  // The row moves forward unless the last slot holds a result that waits.
  logic      adv;
  logic      in_acc;
  pcdt_qry_t chain [TBL_ENTRIES+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  pcdt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_acc  (in_acc),
    .in_item (in_item),
    .q_out   (chain[0])
  );

  // Cell k holds table position k + 1.
  for (genvar k = 0; k < TBL_ENTRIES; k++) begin : g_cell
    pcdt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_pos (CODE_W'(k + 1)),
      .q_in     (chain[k]),
      .q_out    (chain[k+1])
    );
  end

  // A classify item that is still searching after the last cell found
  // neither a match nor a free position.
  always_comb begin
    out_valid           = chain[TBL_ENTRIES].vld;
    out_item.voxel_code = chain[TBL_ENTRIES].code;
    out_item.is_new     = chain[TBL_ENTRIES].is_new;
    out_item.new_color  = chain[TBL_ENTRIES].is_new ? chain[TBL_ENTRIES].color : '0;
    out_item.table_full = chain[TBL_ENTRIES].srch;
  end

`ifndef NO_ASSERTIONS
  a_new_full_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.is_new && out_item.table_full))
    else $error("result is both new and table_full");

  a_new_has_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.is_new) |-> (out_item.voxel_code != '0))
    else $error("new color returned code 0");

  a_full_no_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.table_full) |-> (out_item.voxel_code == '0))
    else $error("table_full result carries a code");

  a_front_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (chain[0].vld && !adv) |=> chain[0].vld)
    else $error("entry stage lost an item while the row was stalled");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette color dedup table.
// ----------------------------------------------------------------------------
// A generator fills a queue of pending items. A clocked driver offers them
// on the input channel. A shadow model of the palette and the distinct-color
// table predicts one result for every accepted item. A clocked monitor
// compares each accepted result, field by field, with the oldest prediction.
// Both sides idle in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb;

  import pcdt_pkg::*;

  // Mode 3 has no meaning for the block. It must come back as an all-zero
  // result.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // The drain wait covers the passage of an item through the palette read
  // and every cell of the row, with some margin.
  localparam int DRAIN_CYCLES = TBL_ENTRIES + 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 40;
  localparam int CALM_ITEMS   = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  pcdt_in_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pcdt_out_t out_item;

  palette_color_dedup_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Items waiting to be offered, and results predicted for accepted items.
  pcdt_in_t  pending_items[$];
  pcdt_out_t awaited_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  // When set, neither side idles. The last part of the run uses it.
  logic calm = 1'b0;

  // --------------------------------------------------------------------------
  // Shadow model of the block.
  // --------------------------------------------------------------------------
  logic [COLOR_W-1:0] pal_shadow [PAL_ENTRIES];
  logic [COLOR_W-1:0] seen_colors[TBL_ENTRIES];
  int                 seen_count = 0;

  // Works out the result of one item and updates the shadow state. Every
  // item gives exactly one result. Loads, clears and the unused mode all
  // give zeros.
  function automatic pcdt_out_t predict_lookup(pcdt_in_t it);
    pcdt_out_t          res;
    logic [COLOR_W-1:0] color;
    logic               hit;
    res = '0;
    case (it.mode)
      MODE_LOAD: begin
        pal_shadow[it.palette_index] = it.color_word;
      end
      MODE_CLEAR: begin
        seen_count = 0;
      end
      MODE_CLASSIFY: begin
        color = pal_shadow[it.palette_index];
        // A color with zero alpha is empty and never enters the table.
        if (color[31:24] != 8'd0) begin
          hit = 1'b0;
          for (int j = 0; j < TBL_ENTRIES; j++) begin
            if (!hit && j < seen_count && seen_colors[j] == color) begin
              hit            = 1'b1;
              res.voxel_code = CODE_W'(j + 1);
            end
          end
          if (!hit) begin
            if (seen_count < TBL_ENTRIES) begin
              seen_colors[seen_count] = color;
              seen_count              = seen_count + 1;
              res.voxel_code          = CODE_W'(seen_count);
              res.is_new              = 1'b1;
              res.new_color           = color;
            end else begin
              // No free position left: the color is reported, not stored.
              res.table_full = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver. The idle decision never looks at in_stall, and a stalled item
  // is held as it is.
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results = {awaited_results, predict_lookup(in_item)};
      end
      if (in_valid && in_stall) begin
        // Hold the item until the block takes it.
      end else if (!calm && send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 6);
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_item  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Checks each accepted result and drives random stall bursts.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    pcdt_out_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result item with no prediction waiting: %p", out_item);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item.voxel_code !== want.voxel_code) begin
            $error("voxel_code: expected %0d, actual %0d",
                   want.voxel_code, out_item.voxel_code);
            error_count++;
          end
          if (out_item.is_new !== want.is_new) begin
            $error("is_new: expected %0b, actual %0b", want.is_new, out_item.is_new);
            error_count++;
          end
          if (out_item.new_color !== want.new_color) begin
            $error("new_color: expected %08h, actual %08h",
                   want.new_color, out_item.new_color);
            error_count++;
          end
          if (out_item.table_full !== want.table_full) begin
            $error("table_full: expected %0b, actual %0b",
                   want.table_full, out_item.table_full);
            error_count++;
          end
        end
      end
      if (!calm && stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own record of which palette
  // slots were loaded, so that a classify item never reads an unwritten slot.
  // --------------------------------------------------------------------------
  logic               slot_loaded[PAL_ENTRIES];
  logic [COLOR_W-1:0] slot_color [PAL_ENTRIES];
  logic [COLOR_W-1:0] popular_colors[16];

  task automatic queue_item(logic [1:0] mode, logic [7:0] idx, logic [COLOR_W-1:0] word);
    pcdt_in_t it;
    it.mode          = mode;
    it.palette_index = idx;
    it.color_word    = word;
    if (mode == MODE_LOAD) begin
      slot_loaded[idx] = 1'b1;
      slot_color[idx]  = word;
    end
    pending_items = {pending_items, it};
  endtask

  // Picks a fresh color for a load. Some have zero alpha, some repeat a
  // small set of colors, and some copy another slot so that different
  // indexes map to the same table entry.
  function automatic logic [COLOR_W-1:0] pick_color();
    logic [COLOR_W-1:0] c;
    int                 sel;
    int                 other;
    sel = $urandom_range(0, 7);
    c   = $urandom;
    if (sel == 0) begin
      c[31:24] = 8'd0;
    end else if (sel <= 3) begin
      c = popular_colors[$urandom_range(0, 15)];
    end else if (sel == 4) begin
      other = $urandom_range(0, PAL_ENTRIES - 1);
      if (slot_loaded[other]) begin
        c = slot_color[other];
      end
    end
    return c;
  endfunction

  task automatic queue_random_item();
    int         roll;
    logic [7:0] idx;
    roll = $urandom_range(0, 99);
    // Half the traffic stays on a few slots so that colors repeat often.
    idx  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    if (roll < 5) begin
      queue_item(MODE_CLEAR, 8'($urandom), $urandom);
    end else if (roll < 9) begin
      queue_item(MODE_UNUSED, 8'($urandom), $urandom);
    end else if (roll < 45 || !slot_loaded[idx]) begin
      queue_item(MODE_LOAD, idx, pick_color());
    end else begin
      queue_item(MODE_CLASSIFY, idx, $urandom);
    end
  endtask

  // Waits until no item is pending, none is offered and no result is due.
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  int scan_order[TBL_ENTRIES];

  initial begin
    int tmp;
    int j;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      slot_loaded[i] = 1'b0;
      slot_color[i]  = '0;
      pal_shadow[i]  = '0;
    end
    for (int i = 0; i < 16; i++) begin
      popular_colors[i] = {8'($urandom_range(1, 255)), 24'($urandom)};
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: alpha extremes, index extremes, hits and misses, reuse
    // of a color from another slot, overwrite of a slot, clear and the
    // unused mode.
    queue_item(MODE_LOAD, 8'd0, 32'h00FF_FFFF);      // zero alpha, other bits set
    queue_item(MODE_LOAD, 8'd255, 32'hFFFF_FFFF);
    queue_item(MODE_LOAD, 8'd1, 32'h0100_0000);      // smallest nonzero alpha
    queue_item(MODE_LOAD, 8'd2, 32'h8012_3456);
    queue_item(MODE_CLASSIFY, 8'd0, 32'hFFFF_FFFF);  // empty voxel
    queue_item(MODE_CLASSIFY, 8'd255, 32'h0000_0000); // first new color
    queue_item(MODE_CLASSIFY, 8'd255, 32'h0000_0000); // same color again
    queue_item(MODE_CLASSIFY, 8'd1, 32'h0000_0000);
    queue_item(MODE_CLASSIFY, 8'd2, 32'h0000_0000);
    queue_item(MODE_UNUSED, 8'd7, 32'h1234_5678);
    queue_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    queue_item(MODE_CLEAR, 8'd0, 32'h0000_0000);
    queue_item(MODE_CLASSIFY, 8'd2, 32'h0000_0000);  // table restarts at one
    queue_item(MODE_CLASSIFY, 8'd255, 32'h0000_0000);
    queue_item(MODE_LOAD, 8'd255, 32'h7F00_0001);    // overwrite a slot
    queue_item(MODE_CLASSIFY, 8'd255, 32'h0000_0000);
    queue_item(MODE_LOAD, 8'd3, 32'h8012_3456);      // same color as slot 2
    queue_item(MODE_CLASSIFY, 8'd3, 32'h0000_0000);
    queue_item(MODE_CLEAR, 8'hFF, 32'hFFFF_FFFF);

    // The sender holds off here until every predicted result has come.
    wait_idle();

    // Fill the table to its last position and go past it. Each slot gets a
    // distinct color through its low byte, so slot 255 holds the one color
    // that finds no room.
    queue_item(MODE_CLEAR, 8'($urandom), $urandom);
    for (int k = 0; k < PAL_ENTRIES; k++) begin
      queue_item(MODE_LOAD, 8'(k), {8'($urandom_range(1, 255)), 16'($urandom), 8'(k)});
    end
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      scan_order[i] = i;
    end
    for (int i = TBL_ENTRIES - 1; i > 0; i--) begin
      j             = $urandom_range(0, i);
      tmp           = scan_order[i];
      scan_order[i] = scan_order[j];
      scan_order[j] = tmp;
    end
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      queue_item(MODE_CLASSIFY, 8'(scan_order[i]), $urandom);
    end
    queue_item(MODE_CLASSIFY, 8'd255, $urandom);     // table full
    for (int i = 0; i < 6; i++) begin
      queue_item(MODE_CLASSIFY, 8'($urandom_range(0, TBL_ENTRIES - 1)), $urandom);
    end
    queue_item(MODE_CLASSIFY, 8'd255, $urandom);     // still full
    queue_item(MODE_CLEAR, 8'($urandom), $urandom);
    queue_item(MODE_CLASSIFY, 8'd255, $urandom);     // room again after clear
    wait_idle();

    // Random part with idling on both sides.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_random_item();
    end
    wait_idle();

    // Final stretch with no idling at all.
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) begin
      queue_random_item();
    end
    wait_idle();

    // Any result that shows up now has no prediction and is caught above.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

endmodule
